/* sv/glob_wildcard_matcher_assert.svh */
// Assertion macros used by the glob wildcard matcher top level.
`ifndef GLOB_WILDCARD_MATCHER_ASSERT_SVH
`define GLOB_WILDCARD_MATCHER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define GWM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glob matcher check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define GWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glob matcher check failed");

`endif

/* sv/gwm_pkg.sv */
// Package with the constants and types shared by the glob wildcard matcher.
package gwm_pkg;

   localparam int PATTERN_LEN = 32;
   localparam int COUNT_W     = $clog2(PATTERN_LEN + 1);
   localparam int ADDR_W      = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;

   localparam logic [7:0] STAR_BYTE  = 8'd42;
   localparam logic [7:0] QMARK_BYTE = 8'd63;
   localparam logic [7:0] UPPER_A    = 8'd65;
   localparam logic [7:0] UPPER_Z    = 8'd90;
   localparam logic [7:0] LOWER_A    = 8'd97;
   localparam logic [7:0] LOWER_Z    = 8'd122;
   localparam logic [7:0] CASE_GAP   = 8'd32;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEXT   = 2'd2,
      CMD_END    = 2'd3
   } gwm_cmd_type;

   // What the pattern store tells the NFA about the loaded pattern.
   typedef struct packed {
      logic [PATTERN_LEN-1:0] star;
      logic [PATTERN_LEN-1:0] hit;
      logic [COUNT_W-1:0]     count;
      logic                   overflow;
   } gwm_pattern_view_type;

endpackage

/* sv/glob_wildcard_matcher.sv */
// Top level of the streaming glob matcher with star and question wildcards.
//
// The req channel carries one beat per command: tuser holds the command
// (clear pattern, append pattern byte, text byte, end of text) and tdata the
// byte. A pattern is loaded first, then text bytes follow, one per beat.
// Only an end-of-text beat produces a rsp beat: tdata bit 0 is the match
// bit and tuser flags a pattern that was longer than the store, in which
// case the match bit reads 0. End of text re-arms the matcher.
// The req beat lands in an input register; the NFA step and the result
// run from it, and the result is registered in the output register.
// One beat is taken per cycle unless an end-of-text beat waits; the NFA
// state register updates once per beat. When the receiver stalls, the result
// waits in the output register; text and pattern beats keep flowing, and only
// an end-of-text beat waits while an earlier result is still held.
// csr_wr_en writes the letter-case mode (1 folds ASCII letters); the user must
// use it only while the block is idle, which the block itself does not enforce.
// Synchronous reset empties the pattern, clears overflow, re-arms the
// matcher, drops any pending beat and sets case folding on.
module glob_wildcard_matcher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] symbol
   input  logic [1:0] req_tuser,   // [1:0] command
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] matched, [7:1] zero
   output logic       rsp_tuser,   // [0] pattern_overflow
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import gwm_pkg::*;

   `include "glob_wildcard_matcher_assert.svh"

   logic                 fold_ff;
   logic                 s1_valid_ff, s1_valid_in;
   gwm_cmd_type          s1_cmd_ff;
   logic [7:0]           s1_symbol_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_matched_ff, rsp_overflow_ff;
   logic                 out_free;
   logic                 s1_go;
   logic                 req_beat;
   logic                 result_load;
   logic                 matched;
   gwm_pattern_view_type view;

   // The output register is free when empty or emptied this cycle.
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign s1_go       = s1_valid_ff && ((s1_cmd_ff != CMD_END) || out_free);
   assign req_tready  = !s1_valid_ff || s1_go;
   assign req_beat    = req_tvalid && req_tready;
   assign result_load = s1_go && (s1_cmd_ff == CMD_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ff <= 1'b1;
      end else if (csr_wr_en) begin
         fold_ff <= csr_wr_data;
      end
   end

   assign s1_valid_in = req_beat || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_cmd_ff    <= gwm_cmd_type'(req_tuser);
         s1_symbol_ff <= req_tdata;
      end
   end

   gwm_pattern_store u_store (
      .clock    (clock),
      .reset    (reset),
      .step_i   (s1_go),
      .cmd_i    (s1_cmd_ff),
      .symbol_i (s1_symbol_ff),
      .fold_i   (fold_ff),
      .view_o   (view)
   );

   gwm_nfa_core u_nfa (
      .clock     (clock),
      .reset     (reset),
      .step_i    (s1_go),
      .cmd_i     (s1_cmd_ff),
      .view_i    (view),
      .matched_o (matched)
   );

   assign rsp_valid_in = result_load || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_matched_ff  <= matched;
         rsp_overflow_ff <= view.overflow;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_matched_ff};
   assign rsp_tuser  = rsp_overflow_ff;

   // A result never claims a match on an overflowed pattern.
   `GWM_ASSERT_NOW(a_no_match_on_overflow, clock, reset, rsp_valid_ff,
                   !(rsp_matched_ff && rsp_overflow_ff))
   // A held end-of-text beat blocks the input channel.
   `GWM_ASSERT_NOW(a_stall_blocks_req, clock, reset, s1_valid_ff && !s1_go, !req_tready)
   // A processed end-of-text beat is offered on the result channel next cycle.
   `GWM_ASSERT_NEXT(a_result_follows_end, clock, reset, result_load, rsp_valid_ff)
   // A result is only loaded into a free output register.
   `GWM_ASSERT_NOW(a_load_into_free, clock, reset, result_load, out_free)

endmodule

/* sv/gwm_pattern_store.sv */
// Pattern byte store with fill count, overflow flag and per-position compare.
module gwm_pattern_store (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_i,
   input  gwm_pkg::gwm_cmd_type          cmd_i,
   input  logic [7:0]                    symbol_i,
   input  logic                          fold_i,
   output gwm_pkg::gwm_pattern_view_type view_o
);
   import gwm_pkg::*;

   logic [7:0]             store_ff [PATTERN_LEN];
   logic [PATTERN_LEN-1:0] live_ff, live_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic                   overflow_ff, overflow_in;
   logic                   full;
   logic                   write_en;

   function automatic logic symbol_match(input logic [7:0] p, input logic [7:0] c,
                                         input logic fold);
      logic letter;
      letter = (p inside {[UPPER_A:UPPER_Z]}) || (p inside {[LOWER_A:LOWER_Z]});
      return (p == c) || (p == QMARK_BYTE) || (fold && letter && ((p ^ CASE_GAP) == c));
   endfunction

   assign full     = live_ff[PATTERN_LEN-1];
   assign write_en = step_i && (cmd_i == CMD_APPEND) && !full;

   always_comb begin
      live_in     = live_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (step_i) begin
         case (cmd_i)
            CMD_CLEAR: begin
               live_in     = '0;
               count_in    = '0;
               overflow_in = 1'b0;
            end
            CMD_APPEND: begin
               if (full) begin
                  overflow_in = 1'b1;
               end else begin
                  live_in  = (live_ff << 1) | PATTERN_LEN'(1);
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff     <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         live_ff     <= live_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         store_ff[count_ff[ADDR_W-1:0]] <= symbol_i;
      end
   end

   // Entries past the fill count are masked by the live bits.
   always_comb begin
      view_o.count    = count_ff;
      view_o.overflow = overflow_ff;
      for (int i = 0; i < PATTERN_LEN; i++) begin
         view_o.star[i] = live_ff[i] && (store_ff[i] == STAR_BYTE);
         view_o.hit[i]  = live_ff[i] && symbol_match(store_ff[i], symbol_i, fold_i);
      end
   end

endmodule

/* sv/gwm_nfa_core.sv */
// Bit-parallel NFA with one active bit per pattern position.
module gwm_nfa_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_i,
   input  gwm_pkg::gwm_cmd_type          cmd_i,
   input  gwm_pkg::gwm_pattern_view_type view_i,
   output logic                          matched_o
);
   import gwm_pkg::*;

   localparam int ACT_W = PATTERN_LEN + 1;

   logic [ACT_W-1:0]       active_ff, active_in;
   logic [ACT_W-1:0]       gen_ext, prop_ext, sum, carry, closed;
   logic [PATTERN_LEN-1:0] stay, advance;

   // Star closure as a carry chain: a star generates a carry where active and
   // propagates one along a run of stars.
   assign gen_ext  = {1'b0, active_ff[PATTERN_LEN-1:0] & view_i.star};
   assign prop_ext = {1'b0, view_i.star};
   assign sum      = gen_ext + prop_ext;
   assign carry    = sum ^ gen_ext ^ prop_ext;
   assign closed   = active_ff | carry;

   assign stay    = closed[PATTERN_LEN-1:0] & view_i.star;
   assign advance = closed[PATTERN_LEN-1:0] & ~view_i.star & view_i.hit;

   assign matched_o = closed[view_i.count] && !view_i.overflow;

   always_comb begin
      active_in = active_ff;
      if (step_i) begin
         case (cmd_i)
            CMD_TEXT: active_in = {1'b0, stay} | {advance, 1'b0};
            default:  active_in = ACT_W'(1);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACT_W'(1);
      end else begin
         active_ff <= active_in;
      end
   end

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the streaming glob wildcard matcher.
`timescale 1ns / 1ps

module testbench;
   import gwm_pkg::*;

   // An end-of-text beat passes the input register and its result the output register.
   // The drain wait lets a text or pattern beat that produces no result finish
   // updating the matcher before the mode register changes.
   localparam int DRAIN_CYCLES = 4;
   localparam int TAIL_CYCLES  = 8;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_BEATS = 2000;
   localparam int PHASES       = 8;
   localparam int REPORT_MAX   = 10;

   localparam logic [PATTERN_LEN:0] START_ONLY = {{PATTERN_LEN{1'b0}}, 1'b1};

   // One expected result: the match bit and the overflow flag.
   typedef struct packed {
      logic matched;
      logic overflow;
   } verdict_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'd0;
   logic [1:0] req_tuser   = CMD_CLEAR;
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       csr_wr_en   = 1'b0;
   logic       csr_wr_data = 1'b0;

   int unsigned cycle_count    = 0;
   int          mismatch_count = 0;
   int          beats_sent     = 0;
   int          req_gap_max    = 12;
   int          rsp_stall_max  = 12;

   // Shadow state of the matcher, updated as each req beat is accepted.
   logic [7:0]           pat_bytes [PATTERN_LEN];
   int                   pat_len   = 0;
   logic [PATTERN_LEN:0] live_pos  = START_ONLY;
   logic                 too_long  = 1'b0;
   logic                 fold_case = 1'b1;

   // Results still owed by the block, oldest first.
   verdict_type verdict_queue[$];

   // Stimulus scratch: the pattern as it was sent, and the text being built.
   logic [7:0] pattern_draft[$];
   logic [7:0] text_draft[$];

   glob_wildcard_matcher dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The run is cut off if it hangs; a correct run ends far below this.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Matcher prediction
   // ---------------------------------------------------------------------

   // Every live position that sits on a star also makes the next one live,
   // which is how a star matches an empty run.
   function automatic void spread_stars();
      for (int i = 0; i < pat_len; i++) begin
         if (live_pos[i] && pat_bytes[i] == STAR_BYTE) begin
            live_pos[i + 1] = 1'b1;
         end
      end
   endfunction

   // A question mark takes any byte; with folding on, a letter in the
   // pattern also takes the same letter in the other case.
   function automatic logic byte_fits(logic [7:0] pat, logic [7:0] chr);
      if (pat == chr || pat == QMARK_BYTE) begin
         return 1'b1;
      end
      if (fold_case && pat >= UPPER_A && pat <= UPPER_Z && pat + CASE_GAP == chr) begin
         return 1'b1;
      end
      if (fold_case && pat >= LOWER_A && pat <= LOWER_Z && pat - CASE_GAP == chr) begin
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advances the shadow matcher by one accepted beat and, for an end of
   // text, queues the result the block owes.
   function automatic void predict_beat(gwm_cmd_type cmd, logic [7:0] sym);
      logic [PATTERN_LEN:0] next_pos;
      verdict_type          verdict;
      case (cmd)
         CMD_CLEAR: begin
            pat_len  = 0;
            too_long = 1'b0;
            live_pos = START_ONLY;
         end
         CMD_APPEND: begin
            // A full store drops the byte and remembers that it overflowed.
            if (pat_len < PATTERN_LEN) begin
               pat_bytes[pat_len] = sym;
               pat_len++;
            end else begin
               too_long = 1'b1;
            end
            live_pos = START_ONLY;
         end
         CMD_TEXT: begin
            spread_stars();
            next_pos = '0;
            for (int i = 0; i < pat_len; i++) begin
               if (live_pos[i]) begin
                  if (pat_bytes[i] == STAR_BYTE) begin
                     next_pos[i] = 1'b1;
                  end else if (byte_fits(pat_bytes[i], sym)) begin
                     next_pos[i + 1] = 1'b1;
                  end
               end
            end
            live_pos = next_pos;
         end
         default: begin
            // The closure runs once more so that trailing stars can match
            // nothing; an overflowed pattern never reports a match.
            spread_stars();
            verdict.matched  = live_pos[pat_len] && !too_long;
            verdict.overflow = too_long;
            verdict_queue.push_back(verdict);
            live_pos = START_ONLY;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   task automatic flag_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
      end
   endtask

   // Each accepted rsp beat is held against the oldest result still owed.
   // The padding bits of tdata must read zero.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (verdict_queue.size() == 0) begin
            flag_error($sformatf("rsp beat tdata=%02h tuser=%0b with no result owed",
                                 rsp_tdata, rsp_tuser));
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_tdata !== {7'd0, want.matched}) begin
               flag_error($sformatf("matched: expected tdata=%02h, got %02h",
                                    {7'd0, want.matched}, rsp_tdata));
            end
            if (rsp_tuser !== want.overflow) begin
               flag_error($sformatf("pattern_overflow: expected %0b, got %0b",
                                    want.overflow, rsp_tuser));
            end
         end
      end
   end

   // The receiver stalls for a random number of cycles before each beat.
   // A stall maximum of zero gives stretches with tready held high.
   initial begin : rsp_receiver
      int stall;
      forever begin
         stall = $urandom_range(0, rsp_stall_max);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Sends one req beat after a random gap and updates the prediction once
   // the beat is taken. tvalid stays high into the next beat when no gap
   // is drawn, so back-to-back beats really are back to back.
   task automatic send_beat(input gwm_cmd_type cmd, input logic [7:0] sym);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= sym;
      do @(posedge clock); while (!req_tready);
      predict_beat(cmd, sym);
      beats_sent++;
   endtask

   // Stops sending and waits until every owed result has arrived, then for the
   // DRAIN_CYCLES wait so that text beats without results have settled.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mode changes happen only with the block idle.
   task automatic write_case_mode(input logic fold);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fold;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      fold_case = fold;
   endtask

   function automatic logic [7:0] random_letter();
      if ($urandom_range(0, 1) == 0) begin
         return 8'($urandom_range(UPPER_A, UPPER_Z));
      end
      return 8'($urandom_range(LOWER_A, LOWER_Z));
   endfunction

   function automatic logic [7:0] random_text_byte();
      if ($urandom_range(0, 99) < 60) begin
         return random_letter();
      end
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic logic [7:0] random_pattern_byte();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 20) begin
         return STAR_BYTE;
      end else if (roll < 35) begin
         return QMARK_BYTE;
      end else if (roll < 80) begin
         return random_letter();
      end
      return 8'($urandom_range(1, 255));
   endfunction

   // Builds a random text, or one that follows the pattern: stars become short runs,
   // question marks any byte, letters flip case at random. One text in
   // four is then spoiled so that near misses are common too.
   function automatic void build_text(input bit follow_pattern);
      logic [7:0] chr;
      text_draft.delete();
      if (!follow_pattern) begin
         repeat ($urandom_range(0, 10)) text_draft.push_back(random_text_byte());
         return;
      end
      foreach (pattern_draft[i]) begin
         chr = pattern_draft[i];
         if (chr == STAR_BYTE) begin
            repeat ($urandom_range(0, 3)) text_draft.push_back(random_text_byte());
         end else if (chr == QMARK_BYTE) begin
            text_draft.push_back(random_text_byte());
         end else begin
            if ((chr inside {[UPPER_A:UPPER_Z], [LOWER_A:LOWER_Z]})
                && $urandom_range(0, 1) == 1) begin
               chr = chr ^ CASE_GAP;
            end
            text_draft.push_back(chr);
         end
      end
      if ($urandom_range(0, 99) < 25) begin
         if (text_draft.size() > 0 && $urandom_range(0, 1) == 1) begin
            text_draft[$urandom_range(0, text_draft.size() - 1)] = random_text_byte();
         end else begin
            text_draft.push_back(random_text_byte());
         end
      end
   endfunction

   // One well-formed session: an optional clear, some pattern bytes, then a
   // few texts each closed by an end-of-text beat.
   task automatic send_session();
      int roll;
      int count;
      if ($urandom_range(0, 99) < 85) begin
         send_beat(CMD_CLEAR, 8'($urandom_range(0, 255)));
         pattern_draft.delete();
      end
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
         count = $urandom_range(0, 8);
      end else if (roll < 92) begin
         count = $urandom_range(9, PATTERN_LEN);
      end else begin
         count = $urandom_range(PATTERN_LEN + 1, PATTERN_LEN + 4);
      end
      repeat (count) begin
         pattern_draft.push_back(random_pattern_byte());
         send_beat(CMD_APPEND, pattern_draft[$]);
      end
      repeat ($urandom_range(1, 4)) begin
         build_text($urandom_range(0, 99) < 75);
         foreach (text_draft[i]) send_beat(CMD_TEXT, text_draft[i]);
         send_beat(CMD_END, 8'($urandom_range(0, 255)));
      end
   endtask

   // A burst of beats in random order, so that texts arrive before
   // patterns, ends arrive back to back and sessions are cut short.
   task automatic send_noise();
      gwm_cmd_type cmd;
      logic [7:0]  sym;
      repeat ($urandom_range(1, 6)) begin
         cmd = gwm_cmd_type'($urandom_range(0, 3));
         sym = 8'($urandom_range(1, 255));
         if (cmd == CMD_CLEAR) begin
            pattern_draft.delete();
         end else if (cmd == CMD_APPEND) begin
            pattern_draft.push_back(sym);
         end
         send_beat(cmd, sym);
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Hand-picked beats with case folding left at its reset value: empty
   // pattern and text, all-star pattern, folding, the question mark against
   // a literal star, the top and bottom byte values and the zero byte.
   task automatic test_directed_cases();
      send_beat(CMD_END, 8'h00);
      send_beat(CMD_CLEAR, 8'hFF);
      send_beat(CMD_APPEND, STAR_BYTE);
      send_beat(CMD_APPEND, STAR_BYTE);
      send_beat(CMD_END, 8'hFF);
      send_beat(CMD_APPEND, "A");
      send_beat(CMD_TEXT, "a");
      send_beat(CMD_END, 8'h00);
      send_beat(CMD_CLEAR, 8'h00);
      send_beat(CMD_APPEND, QMARK_BYTE);
      send_beat(CMD_APPEND, 8'hFF);
      send_beat(CMD_TEXT, STAR_BYTE);
      send_beat(CMD_TEXT, 8'hFF);
      send_beat(CMD_END, 8'h55);
      send_beat(CMD_TEXT, 8'h01);
      send_beat(CMD_END, 8'hAA);
      send_beat(CMD_CLEAR, 8'h01);
      send_beat(CMD_APPEND, 8'h00);
      send_beat(CMD_TEXT, 8'h00);
      send_beat(CMD_END, 8'h00);
   endtask

   // Exact matching: a letter no longer takes its other case, while the
   // question mark still takes a literal star.
   task automatic test_exact_case();
      write_case_mode(1'b0);
      send_beat(CMD_CLEAR, 8'h00);
      send_beat(CMD_APPEND, "a");
      send_beat(CMD_APPEND, QMARK_BYTE);
      send_beat(CMD_TEXT, "A");
      send_beat(CMD_TEXT, "x");
      send_beat(CMD_END, 8'h00);
      send_beat(CMD_TEXT, "a");
      send_beat(CMD_TEXT, STAR_BYTE);
      send_beat(CMD_END, 8'h00);
   endtask

   // A pattern that exactly fills the store matches; one byte more sets the
   // overflow flag and forces the match bit low until the next clear.
   task automatic test_pattern_overflow();
      logic [7:0] chr;
      send_beat(CMD_CLEAR, 8'h00);
      pattern_draft.delete();
      repeat (PATTERN_LEN) begin
         chr = random_letter();
         pattern_draft.push_back(chr);
         send_beat(CMD_APPEND, chr);
      end
      foreach (pattern_draft[i]) send_beat(CMD_TEXT, pattern_draft[i]);
      send_beat(CMD_END, 8'h00);
      send_beat(CMD_APPEND, STAR_BYTE);
      foreach (pattern_draft[i]) send_beat(CMD_TEXT, pattern_draft[i]);
      send_beat(CMD_END, 8'h00);
      send_beat(CMD_END, 8'h00);
      send_beat(CMD_CLEAR, 8'h00);
      send_beat(CMD_END, 8'h00);
   endtask

   // Random sessions over several phases. The phases alternate the case
   // mode and step through every mix of sender gaps and receiver stalls,
   // including phases with no idling at all.
   task automatic test_random_traffic();
      int phase_end;
      for (int phase = 0; phase < PHASES; phase++) begin
         write_case_mode(phase[0]);
         req_gap_max   = (phase % 4 >= 2) ? 0 : 12;
         rsp_stall_max = (phase % 2 == 1) ? 0 : 12;
         phase_end = beats_sent + RANDOM_BEATS / PHASES;
         while (beats_sent < phase_end) begin
            if ($urandom_range(0, 99) < 85) begin
               send_session();
            end else begin
               send_noise();
            end
         end
      end
      req_gap_max   = 12;
      rsp_stall_max = 12;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_exact_case();
      test_pattern_overflow();
      test_random_traffic();
      settle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && verdict_queue.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
